// ----- hdl/dctcp_pkg.sv -----
// Package with the shared types, constants and helper functions of the DCTCP window engine.
package dctcp_pkg;

    localparam int ALPHA_FRAC_BITS_DEF = 16;

    localparam int SEQ_W      = 32;
    localparam int SEG_W      = 16;
    localparam int IW_W       = 5;
    localparam int DUP_W      = 8;
    localparam int GAIN_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_CNT_W  = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SIZE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_WINDOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SSTHRESH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUPACK_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMITED_TRANSMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SHIFT      = 3'd5;

    localparam logic [SEG_W-1:0]  RST_SEGMENT_SIZE     = 16'd536;
    localparam logic [IW_W-1:0]   RST_INITIAL_WINDOW   = 5'd1;
    localparam logic [SEQ_W-1:0]  RST_INITIAL_SSTHRESH = 32'd65535;
    localparam logic [DUP_W-1:0]  RST_DUPACK_THRESHOLD = 8'd3;
    localparam logic              RST_LIMITED_TRANSMIT = 1'b0;
    localparam logic [GAIN_W-1:0] RST_GAIN_SHIFT       = 4'd4;

    typedef enum logic [1:0] {
        OP_CONNECT  = 2'd0,
        OP_NEW_ACK  = 2'd1,
        OP_DUP_ACK  = 2'd2,
        OP_TIMEOUT  = 2'd3
    } t_opcode;

    localparam logic [1:0] CSTATE_UP = 2'd2;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_CONNECT,
        DP_DUP,
        DP_TIMEOUT,
        DP_COUNT,
        DP_ALPHA_START,
        DP_DIV_STEP,
        DP_ALPHA_UPD,
        DP_CUT_MUL,
        DP_CUT_SUB,
        DP_RECOV,
        DP_GROW_SS,
        DP_AVOID_START,
        DP_AVOID_ADD,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        t_opcode opcode;
        logic    no_payload;
        logic    ece;
        logic    boundary;
        logic    dup_trigger;
        logic    div_done;
        logic    partial;
        logic    in_ss;
    } t_dp_status;

    typedef struct packed {
        t_opcode            opcode;
        logic [SEQ_W-1:0]   ack_seq;
        logic               ece_mark;
        logic               ack_has_payload;
        logic [DUP_W-1:0]   dup_count;
        logic [SEQ_W-1:0]   highest_sent_seq;
        logic [SEQ_W-1:0]   bytes_in_flight;
        logic [SEQ_W-1:0]   send_buffer_head_seq;
        logic               unsent_data_pending;
        logic [1:0]         connection_state;
        logic [SEQ_W-1:0]   receiver_window;
    } t_in_item;

    function automatic logic seq_ge(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return !d[SEQ_W-1];
    endfunction

    function automatic logic [SEQ_W-1:0] sat_add(input logic [SEQ_W-1:0] a,
                                                 input logic [SEQ_W-1:0] b);
        logic [SEQ_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SEQ_W] ? '1 : s[SEQ_W-1:0];
    endfunction

    function automatic logic [SEQ_W-1:0] sat_sub(input logic [SEQ_W-1:0] a,
                                                 input logic [SEQ_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    function automatic logic [SEQ_W-1:0] half_flight_floor(input logic [SEQ_W-1:0] bif,
                                                           input logic [SEG_W-1:0] seg);
        logic [SEQ_W-1:0] two;
        logic [SEQ_W-1:0] h;
        two = {{(SEQ_W-SEG_W-1){1'b0}}, seg, 1'b0};
        h   = bif >> 1;
        return (h > two) ? h : two;
    endfunction

endpackage

// ----- hdl/dctcp_if.sv -----
// Valid/ready channel interfaces for the event input and the window result output.
interface dctcp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] ack_seq;
    logic        ece_mark;
    logic        ack_has_payload;
    logic [7:0]  dup_count;
    logic [31:0] highest_sent_seq;
    logic [31:0] bytes_in_flight;
    logic [31:0] send_buffer_head_seq;
    logic        unsent_data_pending;
    logic [1:0]  connection_state;
    logic [31:0] receiver_window;

    modport source (
        output valid, opcode, ack_seq, ece_mark, ack_has_payload, dup_count,
               highest_sent_seq, bytes_in_flight, send_buffer_head_seq,
               unsent_data_pending, connection_state, receiver_window,
        input  ready
    );
    modport sink (
        input  valid, opcode, ack_seq, ece_mark, ack_has_payload, dup_count,
               highest_sent_seq, bytes_in_flight, send_buffer_head_seq,
               unsent_data_pending, connection_state, receiver_window,
        output ready
    );
endinterface

interface dctcp_out_if #(
    parameter int ALPHA_FRAC_BITS = dctcp_pkg::ALPHA_FRAC_BITS_DEF
);
    logic                     valid;
    logic                     ready;
    logic [31:0]              congestion_window;
    logic [31:0]              slow_start_threshold;
    logic [31:0]              send_window;
    logic                     in_fast_recovery;
    logic                     retransmit_request;
    logic                     send_pending_request;
    logic                     limited_transmit_request;
    logic [ALPHA_FRAC_BITS:0] marked_fraction_estimate;

    modport source (
        output valid, congestion_window, slow_start_threshold, send_window,
               in_fast_recovery, retransmit_request, send_pending_request,
               limited_transmit_request, marked_fraction_estimate,
        input  ready
    );
    modport sink (
        input  valid, congestion_window, slow_start_threshold, send_window,
               in_fast_recovery, retransmit_request, send_pending_request,
               limited_transmit_request, marked_fraction_estimate,
        output ready
    );
endinterface

// ----- hdl/dctcp_datapath.sv -----
// Datapath: configuration, window state, shared divider, cut multiplier and result register.
module dctcp_datapath #(
    parameter int ALPHA_FRAC_BITS = dctcp_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dctcp_pkg::t_dp_cmd                   i_cmd,
    input  dctcp_pkg::t_in_item                  i_item,
    input  logic                                 i_cfg_we,
    input  logic [dctcp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dctcp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output dctcp_pkg::t_dp_status                o_status,
    output logic [dctcp_pkg::SEQ_W-1:0]          o_cwnd,
    output logic [dctcp_pkg::SEQ_W-1:0]          o_ssthresh,
    output logic [dctcp_pkg::SEQ_W-1:0]          o_send_window,
    output logic                                 o_fast_recovery,
    output logic                                 o_retransmit,
    output logic                                 o_send_pending,
    output logic                                 o_limited_transmit,
    output logic [ALPHA_FRAC_BITS:0]             o_alpha
);

    localparam int SW     = dctcp_pkg::SEQ_W;
    localparam int F      = ALPHA_FRAC_BITS;
    localparam int PROD_W = SW + F + 1;
    localparam logic [F:0] ALPHA_ONE = {1'b1, {F{1'b0}}};
    localparam logic [PROD_W:0] CUT_ROUND = {{(PROD_W-F){1'b0}}, {(F+1){1'b1}}};
    localparam logic [dctcp_pkg::DIV_CNT_W-1:0] ALPHA_STEPS = dctcp_pkg::DIV_CNT_W'(F);
    localparam logic [dctcp_pkg::DIV_CNT_W-1:0] AVOID_STEPS = dctcp_pkg::DIV_CNT_W'(SW);

    logic [dctcp_pkg::SEG_W-1:0]  r_seg;
    logic [dctcp_pkg::IW_W-1:0]   r_iw;
    logic [SW-1:0]                r_init_ssth;
    logic [dctcp_pkg::DUP_W-1:0]  r_dup_thr;
    logic                         r_ltx_en;
    logic [dctcp_pkg::GAIN_W-1:0] r_gain;

    dctcp_pkg::t_in_item r_in;
    logic [SW-1:0] r_cwnd, r_ssth, r_recovery, r_acked, r_marked, r_window_end, r_last;
    logic          r_flag, r_retx, r_sendp, r_ltx, r_partial;
    logic [F:0]    r_alpha;

    logic [SW:0]   r_div_rem;
    logic [SW-1:0] r_div_quo, r_div_den;
    logic [dctcp_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [PROD_W-1:0] r_prod;

    logic [SW:0]   div_rem_sh;
    logic          div_ge;
    logic [SW-1:0] delta;
    logic [F:0]    frac;
    logic [F:0]    alpha_next;
    logic [PROD_W:0] cut_sum;
    logic [SW-1:0] cut;
    logic [SW-1:0] lim;
    logic [SW-1:0] avoid_add;

    always_comb begin
        div_rem_sh = {r_div_rem[SW-1:0], r_div_quo[SW-1]};
        div_ge     = div_rem_sh >= {1'b0, r_div_den};
        delta      = r_in.ack_seq - r_last;
        if (r_acked == '0) begin
            frac = '0;
        end else if (r_marked >= r_acked) begin
            frac = ALPHA_ONE;
        end else begin
            frac = {1'b0, r_div_quo[F-1:0]};
        end
        alpha_next = r_alpha - (r_alpha >> r_gain) + (frac >> r_gain);
        cut_sum    = {1'b0, r_prod} + CUT_ROUND;
        cut        = cut_sum[F+1 +: SW];
        lim        = dctcp_pkg::sat_add(r_in.bytes_in_flight, {16'd0, r_seg});
        avoid_add  = (r_div_quo == '0) ? SW'(1) : r_div_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg        <= dctcp_pkg::RST_SEGMENT_SIZE;
            r_iw         <= dctcp_pkg::RST_INITIAL_WINDOW;
            r_init_ssth  <= dctcp_pkg::RST_INITIAL_SSTHRESH;
            r_dup_thr    <= dctcp_pkg::RST_DUPACK_THRESHOLD;
            r_ltx_en     <= dctcp_pkg::RST_LIMITED_TRANSMIT;
            r_gain       <= dctcp_pkg::RST_GAIN_SHIFT;
            r_cwnd       <= '0;
            r_ssth       <= '0;
            r_flag       <= 1'b0;
            r_recovery   <= '0;
            r_alpha      <= ALPHA_ONE;
            r_acked      <= '0;
            r_marked     <= '0;
            r_window_end <= '0;
            r_last       <= '0;
            r_retx       <= 1'b0;
            r_sendp      <= 1'b0;
            r_ltx        <= 1'b0;
            r_partial    <= 1'b0;
            r_div_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    dctcp_pkg::CFG_SEGMENT_SIZE:     r_seg       <= i_cfg_data[15:0];
                    dctcp_pkg::CFG_INITIAL_WINDOW:   r_iw        <= i_cfg_data[4:0];
                    dctcp_pkg::CFG_INITIAL_SSTHRESH: r_init_ssth <= i_cfg_data;
                    dctcp_pkg::CFG_DUPACK_THRESHOLD: r_dup_thr   <= i_cfg_data[7:0];
                    dctcp_pkg::CFG_LIMITED_TRANSMIT: r_ltx_en    <= i_cfg_data[0];
                    dctcp_pkg::CFG_GAIN_SHIFT:       r_gain      <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            unique case (i_cmd.op)
                dctcp_pkg::DP_LOAD: begin
                    r_in      <= i_item;
                    r_retx    <= 1'b0;
                    r_sendp   <= 1'b0;
                    r_ltx     <= 1'b0;
                    r_partial <= 1'b0;
                end
                dctcp_pkg::DP_CONNECT: begin
                    r_cwnd <= SW'(r_iw) * SW'(r_seg);
                    r_ssth <= r_init_ssth;
                end
                dctcp_pkg::DP_DUP: begin
                    if (r_in.dup_count == r_dup_thr && !r_flag) begin
                        r_ssth     <= dctcp_pkg::half_flight_floor(r_in.bytes_in_flight, r_seg);
                        r_recovery <= r_in.highest_sent_seq;
                        r_flag     <= 1'b1;
                        r_retx     <= 1'b1;
                    end else if (r_flag) begin
                        r_cwnd  <= dctcp_pkg::sat_add(r_cwnd, {16'd0, r_seg});
                        r_sendp <= 1'b1;
                    end else if (r_ltx_en && r_in.unsent_data_pending) begin
                        r_ltx <= 1'b1;
                    end
                end
                dctcp_pkg::DP_TIMEOUT: begin
                    r_flag <= 1'b0;
                    if (r_in.connection_state >= dctcp_pkg::CSTATE_UP &&
                        !(r_in.connection_state == dctcp_pkg::CSTATE_UP &&
                          dctcp_pkg::seq_ge(r_in.send_buffer_head_seq,
                                            r_in.highest_sent_seq))) begin
                        r_ssth <= dctcp_pkg::half_flight_floor(r_in.bytes_in_flight, r_seg);
                        r_cwnd <= {16'd0, r_seg};
                        r_retx <= 1'b1;
                    end
                end
                dctcp_pkg::DP_COUNT: begin
                    r_last  <= r_in.ack_seq;
                    r_acked <= r_acked + delta;
                    if (r_in.ece_mark) begin
                        r_marked <= r_marked + delta;
                    end
                end
                dctcp_pkg::DP_ALPHA_START: begin
                    r_window_end <= r_in.highest_sent_seq;
                    r_div_rem    <= {1'b0, r_marked};
                    r_div_quo    <= '0;
                    r_div_den    <= r_acked;
                    r_div_cnt    <= ALPHA_STEPS;
                end
                dctcp_pkg::DP_DIV_STEP: begin
                    r_div_rem <= div_ge ? (div_rem_sh - {1'b0, r_div_den}) : div_rem_sh;
                    r_div_quo <= {r_div_quo[SW-2:0], div_ge};
                    r_div_cnt <= r_div_cnt - 1'b1;
                end
                dctcp_pkg::DP_ALPHA_UPD: begin
                    r_alpha  <= alpha_next;
                    r_acked  <= '0;
                    r_marked <= '0;
                end
                dctcp_pkg::DP_CUT_MUL: begin
                    r_prod <= PROD_W'(r_cwnd) * PROD_W'(r_alpha);
                end
                dctcp_pkg::DP_CUT_SUB: begin
                    r_cwnd <= dctcp_pkg::sat_sub(r_cwnd, cut);
                end
                dctcp_pkg::DP_RECOV: begin
                    if (r_flag && !dctcp_pkg::seq_ge(r_in.ack_seq, r_recovery)) begin
                        r_cwnd <= dctcp_pkg::sat_add(
                            dctcp_pkg::sat_sub(r_cwnd, r_in.ack_seq - r_in.send_buffer_head_seq),
                            {16'd0, r_seg});
                        r_retx    <= 1'b1;
                        r_sendp   <= 1'b1;
                        r_partial <= 1'b1;
                    end else if (r_flag) begin
                        r_cwnd <= (r_ssth < lim) ? r_ssth : lim;
                        r_flag <= 1'b0;
                    end
                end
                dctcp_pkg::DP_GROW_SS: begin
                    r_cwnd  <= dctcp_pkg::sat_add(r_cwnd, {16'd0, r_seg});
                    r_sendp <= 1'b1;
                end
                dctcp_pkg::DP_AVOID_START: begin
                    r_div_rem <= '0;
                    r_div_quo <= SW'(r_seg) * SW'(r_seg);
                    r_div_den <= (r_cwnd == '0) ? SW'(1) : r_cwnd;
                    r_div_cnt <= AVOID_STEPS;
                end
                dctcp_pkg::DP_AVOID_ADD: begin
                    r_cwnd  <= dctcp_pkg::sat_add(r_cwnd, avoid_add);
                    r_sendp <= 1'b1;
                end
                dctcp_pkg::DP_OUT: begin
                    o_cwnd             <= r_cwnd;
                    o_ssthresh         <= r_ssth;
                    o_send_window      <= (r_in.receiver_window < r_cwnd) ?
                                          r_in.receiver_window : r_cwnd;
                    o_fast_recovery    <= r_flag;
                    o_retransmit       <= r_retx;
                    o_send_pending     <= r_sendp;
                    o_limited_transmit <= r_ltx;
                    o_alpha            <= r_alpha;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_status.opcode      = r_in.opcode;
        o_status.no_payload  = !r_in.ack_has_payload;
        o_status.ece         = r_in.ece_mark;
        o_status.boundary    = dctcp_pkg::seq_ge(r_in.ack_seq, r_window_end);
        o_status.dup_trigger = (r_in.dup_count == r_dup_thr) && !r_flag;
        o_status.div_done    = (r_div_cnt == '0);
        o_status.partial     = r_partial;
        o_status.in_ss       = (r_cwnd < r_ssth);
    end

endmodule

// ----- hdl/dctcp_controller.sv -----
// Controller state machine that sequences the datapath through each event.
module dctcp_controller (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    input  dctcp_pkg::t_dp_status i_status,
    output dctcp_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_COUNT,
        S_ALPHA_START,
        S_ALPHA_DIV,
        S_ALPHA_UPD,
        S_CUT_MUL,
        S_CUT_SUB,
        S_RECOV,
        S_GROW,
        S_AVOID_DIV,
        S_AVOID_ADD,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = dctcp_pkg::DP_NOP;
        o_in_ready  = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = dctcp_pkg::DP_LOAD;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_status.opcode)
                    dctcp_pkg::OP_CONNECT: begin
                        o_cmd.op = dctcp_pkg::DP_CONNECT;
                        n_state  = S_FINISH;
                    end
                    dctcp_pkg::OP_NEW_ACK: begin
                        n_state = i_status.no_payload ? S_COUNT : S_RECOV;
                    end
                    dctcp_pkg::OP_DUP_ACK: begin
                        o_cmd.op = dctcp_pkg::DP_DUP;
                        n_state  = i_status.dup_trigger ? S_CUT_MUL : S_FINISH;
                    end
                    dctcp_pkg::OP_TIMEOUT: begin
                        o_cmd.op = dctcp_pkg::DP_TIMEOUT;
                        n_state  = S_FINISH;
                    end
                    default: ;
                endcase
            end
            S_COUNT: begin
                o_cmd.op = dctcp_pkg::DP_COUNT;
                priority if (i_status.boundary) begin
                    n_state = S_ALPHA_START;
                end else if (i_status.ece) begin
                    n_state = S_CUT_MUL;
                end else begin
                    n_state = S_RECOV;
                end
            end
            S_ALPHA_START: begin
                o_cmd.op = dctcp_pkg::DP_ALPHA_START;
                n_state  = S_ALPHA_DIV;
            end
            S_ALPHA_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_ALPHA_UPD;
                end else begin
                    o_cmd.op = dctcp_pkg::DP_DIV_STEP;
                end
            end
            S_ALPHA_UPD: begin
                o_cmd.op = dctcp_pkg::DP_ALPHA_UPD;
                n_state  = i_status.ece ? S_CUT_MUL : S_RECOV;
            end
            S_CUT_MUL: begin
                o_cmd.op = dctcp_pkg::DP_CUT_MUL;
                n_state  = S_CUT_SUB;
            end
            S_CUT_SUB: begin
                o_cmd.op = dctcp_pkg::DP_CUT_SUB;
                n_state  = (i_status.opcode == dctcp_pkg::OP_DUP_ACK) ? S_FINISH : S_RECOV;
            end
            S_RECOV: begin
                o_cmd.op = dctcp_pkg::DP_RECOV;
                n_state  = S_GROW;
            end
            S_GROW: begin
                priority if (i_status.partial) begin
                    n_state = S_FINISH;
                end else if (i_status.in_ss) begin
                    o_cmd.op = dctcp_pkg::DP_GROW_SS;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.op = dctcp_pkg::DP_AVOID_START;
                    n_state  = S_AVOID_DIV;
                end
            end
            S_AVOID_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_AVOID_ADD;
                end else begin
                    o_cmd.op = dctcp_pkg::DP_DIV_STEP;
                end
            end
            S_AVOID_ADD: begin
                o_cmd.op = dctcp_pkg::DP_AVOID_ADD;
                n_state  = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = dctcp_pkg::DP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hdl/dctcp_congestion_window_top.sv -----
// Top level of the DCTCP congestion window engine.
//
// Channel   Direction  Transaction
// in_ch     sink       one event (connect, new ACK, duplicate ACK, timeout)
// out_ch    source     one window result per event
// i_cfg_*   write      one configuration register write
//
// An event is worked through in full before the next event can be taken; the longest is a
// pure marked new ACK at a window boundary in congestion avoidance, set by the shared
// restoring divider, which gives one quotient bit a cycle (ALPHA_FRAC_BITS bits for alpha,
// 32 for the increase).
// Reset is synchronous and active low; it needs no clearing pass.
// A finished result waits in the output register while the next event is taken in;
// the engine stalls at its last step only while an earlier result is still unread.
module dctcp_congestion_window_top #(
    parameter int ALPHA_FRAC_BITS = dctcp_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    dctcp_in_if.sink                         in_ch,
    dctcp_out_if.source                      out_ch,
    input  logic                             i_cfg_we,
    input  logic [dctcp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dctcp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    dctcp_pkg::t_dp_cmd    cmd;
    dctcp_pkg::t_dp_status status;
    dctcp_pkg::t_in_item   item;
    logic [ALPHA_FRAC_BITS:0] alpha;

    always_comb begin
        item.opcode               = dctcp_pkg::t_opcode'(in_ch.opcode);
        item.ack_seq              = in_ch.ack_seq;
        item.ece_mark             = in_ch.ece_mark;
        item.ack_has_payload      = in_ch.ack_has_payload;
        item.dup_count            = in_ch.dup_count;
        item.highest_sent_seq     = in_ch.highest_sent_seq;
        item.bytes_in_flight      = in_ch.bytes_in_flight;
        item.send_buffer_head_seq = in_ch.send_buffer_head_seq;
        item.unsent_data_pending  = in_ch.unsent_data_pending;
        item.connection_state     = in_ch.connection_state;
        item.receiver_window      = in_ch.receiver_window;
    end

    dctcp_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .i_out_ready (out_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    dctcp_datapath #(
        .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_item             (item),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_status           (status),
        .o_cwnd             (out_ch.congestion_window),
        .o_ssthresh         (out_ch.slow_start_threshold),
        .o_send_window      (out_ch.send_window),
        .o_fast_recovery    (out_ch.in_fast_recovery),
        .o_retransmit       (out_ch.retransmit_request),
        .o_send_pending     (out_ch.send_pending_request),
        .o_limited_transmit (out_ch.limited_transmit_request),
        .o_alpha            (alpha)
    );

    assign out_ch.marked_fraction_estimate = alpha;

    localparam logic [ALPHA_FRAC_BITS:0] ALPHA_ONE = {1'b1, {ALPHA_FRAC_BITS{1'b0}}};

    a_alpha_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> out_ch.marked_fraction_estimate <= ALPHA_ONE)
        else $error("alpha estimate exceeds one");

    a_one_event_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input taken while an event is in progress");

    a_send_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> out_ch.send_window <= out_ch.congestion_window)
        else $error("send window above congestion window");

    a_request_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> !(out_ch.retransmit_request && out_ch.limited_transmit_request))
        else $error("retransmit and limited transmit requested together");

endmodule

// ----- bench/dctcp_congestion_window_top_tb.sv -----
// Self-checking testbench for the DCTCP congestion window engine with a predicting scoreboard.
module dctcp_congestion_window_top_tb;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] cwnd;
        logic [31:0] ssthresh;
        logic [31:0] swnd;
        logic        in_fr;
        logic        retx;
        logic        sendp;
        logic        ltx;
        logic [16:0] alpha;
    } t_window_result;

    class window_scoreboard;
        logic [15:0] seg_size;
        logic [4:0]  init_win;
        logic [31:0] init_ssthresh;
        logic [7:0]  dup_thresh;
        logic        ltx_en;
        logic [3:0]  gain;
        logic [31:0] cwnd;
        logic [31:0] ssthresh;
        logic        fr;
        logic [31:0] recover_seq;
        logic [31:0] alpha;
        logic [31:0] acked_bytes;
        logic [31:0] marked_bytes;
        logic [31:0] win_end;
        logic [31:0] last_seq;
        t_window_result pending[$];
        int mismatches;

        function new();
            seg_size = dctcp_pkg::RST_SEGMENT_SIZE;
            init_win = dctcp_pkg::RST_INITIAL_WINDOW;
            init_ssthresh = dctcp_pkg::RST_INITIAL_SSTHRESH;
            dup_thresh = dctcp_pkg::RST_DUPACK_THRESHOLD;
            ltx_en = dctcp_pkg::RST_LIMITED_TRANSMIT;
            gain = dctcp_pkg::RST_GAIN_SHIFT;
            cwnd = 0;
            ssthresh = 0;
            fr = 0;
            recover_seq = 0;
            alpha = 32'd1 << 16;
            acked_bytes = 0;
            marked_bytes = 0;
            win_end = 0;
            last_seq = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                dctcp_pkg::CFG_SEGMENT_SIZE:     seg_size = val[15:0];
                dctcp_pkg::CFG_INITIAL_WINDOW:   init_win = val[4:0];
                dctcp_pkg::CFG_INITIAL_SSTHRESH: init_ssthresh = val;
                dctcp_pkg::CFG_DUPACK_THRESHOLD: dup_thresh = val[7:0];
                dctcp_pkg::CFG_LIMITED_TRANSMIT: ltx_en = val[0];
                dctcp_pkg::CFG_GAIN_SHIFT:       gain = val[3:0];
                default: ;
            endcase
        endfunction

        function logic serial_ge(logic [31:0] a, logic [31:0] b);
            logic [31:0] d;
            d = a - b;
            return !d[31];
        endfunction

        function logic [31:0] add_sat(logic [31:0] a, logic [63:0] b);
            logic [63:0] s;
            s = {32'd0, a} + b;
            return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function logic [31:0] sub_sat(logic [31:0] a, logic [31:0] b);
            return (a > b) ? a - b : 32'd0;
        endfunction

        function logic [31:0] alpha_cut(logic [31:0] w);
            logic [63:0] prod;
            logic [63:0] cut;
            prod = {32'd0, w} * {32'd0, alpha};
            cut = (prod + 64'd131071) / 64'd131072;
            return sub_sat(w, (cut > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cut[31:0]);
        endfunction

        function logic [31:0] flight_half(logic [31:0] bif);
            logic [31:0] two;
            two = {15'd0, seg_size, 1'b0};
            return ((bif >> 1) > two) ? (bif >> 1) : two;
        endfunction

        function void note_event(dctcp_pkg::t_in_item it);
            t_window_result r;
            logic partial;
            logic [31:0] delta;
            logic [63:0] frac;
            logic [63:0] incr;
            r = '0;
            partial = 0;
            case (it.opcode)
                dctcp_pkg::OP_CONNECT: begin
                    cwnd = 32'(init_win) * 32'(seg_size);
                    ssthresh = init_ssthresh;
                end
                dctcp_pkg::OP_NEW_ACK: begin
                    if (!it.ack_has_payload) begin
                        delta = it.ack_seq - last_seq;
                        last_seq = it.ack_seq;
                        acked_bytes += delta;
                        if (it.ece_mark) marked_bytes += delta;
                        if (serial_ge(it.ack_seq, win_end)) begin
                            frac = 0;
                            win_end = it.highest_sent_seq;
                            if (acked_bytes != 0) begin
                                frac = ({32'd0, marked_bytes} << 16) / acked_bytes;
                                if (frac > 64'd65536) frac = 64'd65536;
                            end
                            alpha = alpha - (alpha >> gain) + 32'(frac >> gain);
                            acked_bytes = 0;
                            marked_bytes = 0;
                        end
                        if (it.ece_mark) cwnd = alpha_cut(cwnd);
                    end
                    if (fr && !serial_ge(it.ack_seq, recover_seq)) begin
                        cwnd = sub_sat(cwnd, it.ack_seq - it.send_buffer_head_seq);
                        cwnd = add_sat(cwnd, 64'(seg_size));
                        r.retx = 1;
                        r.sendp = 1;
                        partial = 1;
                    end else if (fr) begin
                        delta = add_sat(it.bytes_in_flight, 64'(seg_size));
                        cwnd = (ssthresh < delta) ? ssthresh : delta;
                        fr = 0;
                    end
                    if (!partial) begin
                        if (cwnd < ssthresh) begin
                            cwnd = add_sat(cwnd, 64'(seg_size));
                        end else begin
                            incr = (64'(seg_size) * 64'(seg_size)) /
                                   ((cwnd != 0) ? 64'(cwnd) : 64'd1);
                            if (incr < 1) incr = 1;
                            cwnd = add_sat(cwnd, incr);
                        end
                        r.sendp = 1;
                    end
                end
                dctcp_pkg::OP_DUP_ACK: begin
                    if (it.dup_count == dup_thresh && !fr) begin
                        ssthresh = flight_half(it.bytes_in_flight);
                        cwnd = alpha_cut(cwnd);
                        recover_seq = it.highest_sent_seq;
                        fr = 1;
                        r.retx = 1;
                    end else if (fr) begin
                        cwnd = add_sat(cwnd, 64'(seg_size));
                        r.sendp = 1;
                    end else if (ltx_en && it.unsent_data_pending) begin
                        r.ltx = 1;
                    end
                end
                default: begin
                    fr = 0;
                    if (it.connection_state >= dctcp_pkg::CSTATE_UP &&
                        !(it.connection_state == dctcp_pkg::CSTATE_UP &&
                          serial_ge(it.send_buffer_head_seq, it.highest_sent_seq))) begin
                        ssthresh = flight_half(it.bytes_in_flight);
                        cwnd = 32'(seg_size);
                        r.retx = 1;
                    end
                end
            endcase
            r.cwnd = cwnd;
            r.ssthresh = ssthresh;
            r.swnd = (it.receiver_window < cwnd) ? it.receiver_window : cwnd;
            r.in_fr = fr;
            r.alpha = alpha[16:0];
            pending.push_back(r);
        endfunction

        function void check_result(t_window_result act);
            t_window_result exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", act);
                return;
            end
            exp_r = pending.pop_front();
            if (act !== exp_r) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, act);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    dctcp_in_if  in_ch ();
    dctcp_out_if out_ch ();

    dctcp_congestion_window_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch.sink),
        .out_ch      (out_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    window_scoreboard sb = new();
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;
    int  quiet_cycles;
    bit  failed;
    logic [31:0] seq_base;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        dctcp_pkg::t_in_item it;
        if (in_ch.valid && in_ch.ready) begin
            it.opcode = dctcp_pkg::t_opcode'(in_ch.opcode);
            it.ack_seq = in_ch.ack_seq;
            it.ece_mark = in_ch.ece_mark;
            it.ack_has_payload = in_ch.ack_has_payload;
            it.dup_count = in_ch.dup_count;
            it.highest_sent_seq = in_ch.highest_sent_seq;
            it.bytes_in_flight = in_ch.bytes_in_flight;
            it.send_buffer_head_seq = in_ch.send_buffer_head_seq;
            it.unsent_data_pending = in_ch.unsent_data_pending;
            it.connection_state = in_ch.connection_state;
            it.receiver_window = in_ch.receiver_window;
            sb.note_event(it);
        end
        if (out_ch.valid && out_ch.ready) begin
            sb.check_result({out_ch.congestion_window, out_ch.slow_start_threshold,
                             out_ch.send_window, out_ch.in_fast_recovery,
                             out_ch.retransmit_request, out_ch.send_pending_request,
                             out_ch.limited_transmit_request,
                             out_ch.marked_fraction_estimate});
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("dctcp_congestion_window_top verification failed");
            $finish;
        end
    end

    // The receiver stalls at random; a long hold-off is counted here.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            out_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Valid stays high after a transaction until the next call or a drain lowers it.
    task automatic send_event(dctcp_pkg::t_in_item it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= it.opcode;
        in_ch.ack_seq <= it.ack_seq;
        in_ch.ece_mark <= it.ece_mark;
        in_ch.ack_has_payload <= it.ack_has_payload;
        in_ch.dup_count <= it.dup_count;
        in_ch.highest_sent_seq <= it.highest_sent_seq;
        in_ch.bytes_in_flight <= it.bytes_in_flight;
        in_ch.send_buffer_head_seq <= it.send_buffer_head_seq;
        in_ch.unsent_data_pending <= it.unsent_data_pending;
        in_ch.connection_state <= it.connection_state;
        in_ch.receiver_window <= it.receiver_window;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    function automatic dctcp_pkg::t_in_item make_event(dctcp_pkg::t_opcode op);
        dctcp_pkg::t_in_item it;
        logic [255:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(dctcp_pkg::t_in_item)-1:0];
        it.opcode = op;
        it.ece_mark = 1'($urandom_range(1));
        it.ack_has_payload = ($urandom_range(3) == 0);
        it.dup_count = $urandom_range(3) == 0 ? 8'($urandom) : 8'(sb.dup_thresh);
        it.connection_state = 2'($urandom_range(3));
        it.unsent_data_pending = 1'($urandom_range(1));
        it.receiver_window = $urandom_range(3) == 0 ? $urandom : $urandom_range(200000);
        return it;
    endfunction

    // A connection's life: connect, ACKs that mostly advance but sometimes step back, loss and recovery.
    task automatic run_flow(int count);
        dctcp_pkg::t_in_item it;
        int k;
        int mode;
        logic [31:0] ack;
        ack = seq_base;
        it = make_event(dctcp_pkg::OP_CONNECT);
        send_event(it);
        for (k = 0; k < count; k++) begin
            mode = $urandom_range(99);
            if (mode < 55) begin
                it = make_event(dctcp_pkg::OP_NEW_ACK);
                it.send_buffer_head_seq = ack;
                ack = ack + $urandom_range(3000);
                if ($urandom_range(9) == 0) ack = ack - $urandom_range(2000);
                it.ack_seq = ack;
                it.highest_sent_seq = ack + $urandom_range(20000);
                it.bytes_in_flight = $urandom_range(40000);
            end else if (mode < 80) begin
                it = make_event(dctcp_pkg::OP_DUP_ACK);
                it.ack_seq = ack;
                it.highest_sent_seq = ack + $urandom_range(20000);
                it.bytes_in_flight = $urandom_range(40000);
                it.dup_count = $urandom_range(1) ? 8'(sb.dup_thresh) : 8'($urandom_range(6));
            end else if (mode < 85) begin
                it = make_event(dctcp_pkg::OP_TIMEOUT);
                it.send_buffer_head_seq = ack;
                it.highest_sent_seq = ack + $urandom_range(20000) - 5000;
            end else if (mode < 90) begin
                it = make_event(dctcp_pkg::OP_CONNECT);
            end else begin
                it = make_event(dctcp_pkg::t_opcode'($urandom_range(3)));
            end
            send_event(it);
        end
        seq_base = ack;
    endtask

    task automatic run_directed();
        dctcp_pkg::t_in_item it;
        int k;
        for (k = 0; k < 4; k++) begin
            it = '0;
            it.opcode = dctcp_pkg::t_opcode'(k);
            send_event(it);
            it = '1;
            it.opcode = dctcp_pkg::t_opcode'(k);
            send_event(it);
        end
        it = make_event(dctcp_pkg::OP_CONNECT);
        send_event(it);
        it = '0;
        it.opcode = dctcp_pkg::OP_DUP_ACK;
        it.dup_count = sb.dup_thresh;
        it.highest_sent_seq = 32'd10000;
        it.bytes_in_flight = 32'd8000;
        send_event(it);
        it.dup_count = 8'(sb.dup_thresh + 8'd1);
        send_event(it);
        it.opcode = dctcp_pkg::OP_NEW_ACK;
        it.ack_seq = 32'd3000;
        it.send_buffer_head_seq = 32'd1000;
        it.ece_mark = 1'b1;
        send_event(it);
        it.ack_seq = 32'd12000;
        send_event(it);
        it.ack_seq = 32'h8000_0000;
        it.receiver_window = 32'hFFFF_FFFF;
        send_event(it);
        it.opcode = dctcp_pkg::OP_TIMEOUT;
        it.connection_state = dctcp_pkg::CSTATE_UP;
        it.send_buffer_head_seq = 32'd5;
        it.highest_sent_seq = 32'd5;
        send_event(it);
        it.connection_state = 2'd3;
        send_event(it);
        it.opcode = dctcp_pkg::OP_CONNECT;
        send_event(it);
        it.opcode = dctcp_pkg::OP_NEW_ACK;
        it.ece_mark = 1'b0;
        it.ack_seq = 32'h8000_0000;
        send_event(it);
    endtask

    initial begin
        int phase;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = '0;
        in_ch.ack_seq = '0;
        in_ch.ece_mark = 1'b0;
        in_ch.ack_has_payload = 1'b0;
        in_ch.dup_count = '0;
        in_ch.highest_sent_seq = '0;
        in_ch.bytes_in_flight = '0;
        in_ch.send_buffer_head_seq = '0;
        in_ch.unsent_data_pending = 1'b0;
        in_ch.connection_state = '0;
        in_ch.receiver_window = '0;
        out_ch.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        failed = 1'b0;
        seq_base = $urandom;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        drain_results();

        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            case (phase)
                0: begin
                    write_reg(dctcp_pkg::CFG_SEGMENT_SIZE, 32'd1);
                    write_reg(dctcp_pkg::CFG_INITIAL_WINDOW, 32'd1);
                    write_reg(dctcp_pkg::CFG_INITIAL_SSTHRESH, 32'd0);
                    write_reg(dctcp_pkg::CFG_DUPACK_THRESHOLD, 32'd1);
                    write_reg(dctcp_pkg::CFG_LIMITED_TRANSMIT, 32'd1);
                    write_reg(dctcp_pkg::CFG_GAIN_SHIFT, 32'd1);
                end
                1: begin
                    write_reg(dctcp_pkg::CFG_SEGMENT_SIZE, 32'd65535);
                    write_reg(dctcp_pkg::CFG_INITIAL_WINDOW, 32'd16);
                    write_reg(dctcp_pkg::CFG_INITIAL_SSTHRESH, 32'hFFFF_FFFF);
                    write_reg(dctcp_pkg::CFG_DUPACK_THRESHOLD, 32'd255);
                    write_reg(dctcp_pkg::CFG_GAIN_SHIFT, 32'd15);
                end
                4: begin
                    write_reg(3'd7, $urandom);
                    write_reg(dctcp_pkg::CFG_LIMITED_TRANSMIT, 32'd0);
                end
                default: begin
                    write_reg(dctcp_pkg::CFG_SEGMENT_SIZE, $urandom_range(65535, 1));
                    write_reg(dctcp_pkg::CFG_INITIAL_WINDOW, $urandom_range(16, 1));
                    write_reg(dctcp_pkg::CFG_INITIAL_SSTHRESH, $urandom_range(3) == 0 ?
                              $urandom : $urandom_range(300000));
                    write_reg(dctcp_pkg::CFG_DUPACK_THRESHOLD, $urandom_range(5, 1));
                    write_reg(dctcp_pkg::CFG_LIMITED_TRANSMIT, $urandom_range(1));
                    write_reg(dctcp_pkg::CFG_GAIN_SHIFT, $urandom_range(15, 1));
                end
            endcase
            if (phase == 2) begin
                @(negedge i_clk);
                hold_cycles <= 600;
            end
            run_flow(225);
            drain_results();
        end

        if (sb.mismatches != 0 || sb.pending.size() != 0) failed = 1'b1;
        if (!failed) begin
            $display("dctcp_congestion_window_top verification clean");
        end else begin
            $display("dctcp_congestion_window_top verification failed");
        end
        $finish;
    end
endmodule
